/* rtl/efws_pkg.sv */
// Package for the earliest-free-worker scheduler.
// Holds default parameters, field widths, register map and the controller/datapath structs.
// No dependencies.
`default_nettype none
package efws_pkg;

    localparam int DEF_MAX_WORKERS = 16;
    localparam int DEF_TIME_BITS   = 48;

    localparam int DUR_W   = 32;
    localparam int IDX_W   = 4;
    localparam int START_W = 48;
    localparam int ACT_W   = 5;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // Word index of the worker-count register (paddr[2]).
    localparam logic REG_ACTIVE = 1'b0;

    localparam logic [ACT_W-1:0] ACTIVE_RESET = 5'd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the job duration
        logic issue;    // read one worker's free time
        logic first;    // this read starts a new search
        logic update;   // write back the chosen worker and load the result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_hold; // result register is full and not taken this cycle
    } t_sts;

endpackage
`default_nettype wire

/* rtl/efws_ctrl.sv */
// Controller of the earliest-free-worker scheduler: state machine and scan counter.
// Depends on efws_pkg; drives the datapath through t_cmd and reads t_sts.
`default_nettype none
module efws_ctrl
    import efws_pkg::*;
#(
    parameter int USED  = 16,
    parameter int CNT_W = 5,
    parameter int AW    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [ACT_W-1:0] i_active,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_sts             i_sts,
    output t_cmd                  o_cmd,
    output logic [AW-1:0]         o_rd_addr
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_UPDATE = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] count;
    logic             last;

    // A count of zero means one worker; above the storage depth it saturates.
    always_comb begin
        if (i_active == '0) begin
            count = CNT_W'(1);
        end else if (32'(i_active) > 32'(USED)) begin
            count = CNT_W'(USED);
        end else begin
            count = CNT_W'(i_active);
        end
    end

    assign last       = (r_cnt == count - CNT_W'(1));
    assign o_in_ready = (r_state == S_IDLE);
    assign o_rd_addr  = r_cnt[AW-1:0];

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                o_cmd.first = (r_cnt == '0);
                n_cnt       = r_cnt + CNT_W'(1);
                if (last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (!i_sts.out_hold) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
`default_nettype wire

/* rtl/efws_dp.sv */
// Datapath of the earliest-free-worker scheduler: free-time memory, running minimum,
// saturating update and result register. Depends on efws_pkg.
`default_nettype none
module efws_dp
    import efws_pkg::*;
#(
    parameter int USED      = 16,
    parameter int AW        = 4,
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire logic [AW-1:0]      i_rd_addr,
    input  wire logic [DUR_W-1:0]   i_job_duration,
    output t_sts                    o_sts,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [IDX_W-1:0]        o_worker_index,
    output logic [START_W-1:0]      o_start_time
);

    logic [TIME_BITS-1:0] r_mem [USED];
    logic [USED-1:0]      r_vld;

    logic [DUR_W-1:0]     r_dur;
    logic [TIME_BITS-1:0] r_rd_data;
    logic                 r_rd_ok;
    logic [AW-1:0]        r_rd_idx;
    logic                 r_cmp, r_cmp_first;
    logic [TIME_BITS-1:0] r_best;
    logic [AW-1:0]        r_best_idx;
    logic                 r_out_valid;
    logic [IDX_W-1:0]     r_out_idx;
    logic [START_W-1:0]   r_out_start;

    logic [TIME_BITS-1:0] rd_time;
    logic [TIME_BITS:0]   sum;
    logic [TIME_BITS-1:0] next_time;
    logic [63:0]          best_wide;
    logic [63:0]          idx_wide;

    // An entry never written since reset reads as time zero.
    assign rd_time   = r_rd_ok ? r_rd_data : '0;
    assign sum       = (TIME_BITS+1)'(r_best) + (TIME_BITS+1)'(r_dur);
    assign next_time = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
    assign best_wide = 64'(r_best);
    assign idx_wide  = 64'(r_best_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_cmd.update) begin
            r_mem[r_best_idx] <= next_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_cmp       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmp <= i_cmd.issue;
            if (i_cmd.update) begin
                r_vld[r_best_idx] <= 1'b1;
            end
            if (i_cmd.update) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dur <= i_job_duration;
        end
        if (i_cmd.issue) begin
            r_rd_ok     <= r_vld[i_rd_addr];
            r_rd_idx    <= i_rd_addr;
            r_cmp_first <= i_cmd.first;
        end
        // Strictly less keeps the lowest index among equal free times.
        if (r_cmp && (r_cmp_first || rd_time < r_best)) begin
            r_best     <= rd_time;
            r_best_idx <= r_rd_idx;
        end
        if (i_cmd.update) begin
            r_out_idx   <= idx_wide[IDX_W-1:0];
            r_out_start <= best_wide[START_W-1:0];
        end
    end

    assign o_sts.out_hold = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_worker_index = r_out_idx;
    assign o_start_time   = r_out_start;

endmodule
`default_nettype wire

/* rtl/earliest_free_worker_scheduler.sv */
// Top level of the earliest-free-worker scheduler: register port and the two blocks.
// Depends on efws_pkg, efws_ctrl and efws_dp.
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_ready    i_job_duration [31:0]
//  output    out        o_out_valid / i_out_ready  o_worker_index [3:0], o_start_time [47:0]
//  config    in         psel/penable/pwrite        paddr [2:0], pwdata, prdata; pready = 1
//
// The free-time memory has one read port, so the minimum search reads one worker per
// cycle over the effective worker count; a drain state then finishes the compare and an
// update state writes the worker back and loads the result register.
// Reset is synchronous; free times read as zero until a worker is first chosen.
// A full result register stalls only the final write-back step; a new item may be
// accepted and searched while the previous result waits.
`default_nettype none
module earliest_free_worker_scheduler
    import efws_pkg::*;
#(
    parameter int MAX_WORKERS = DEF_MAX_WORKERS,
    parameter int TIME_BITS   = DEF_TIME_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [APB_AW-1:0]  paddr,
    input  wire logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]       prdata,
    output logic                    pready,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [DUR_W-1:0]   i_job_duration,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [IDX_W-1:0]        o_worker_index,
    output logic [START_W-1:0]      o_start_time
);

    // The count register reaches 31 at most, so no more workers are ever used.
    localparam int MAX_CNT = (1 << ACT_W) - 1;
    localparam int USED    = (MAX_WORKERS < MAX_CNT) ? MAX_WORKERS : MAX_CNT;
    localparam int CNT_W   = $clog2(USED + 1);
    localparam int AW      = (USED > 1) ? $clog2(USED) : 1;

    logic [ACT_W-1:0] r_active;
    t_cmd             cmd;
    t_sts             sts;
    logic [AW-1:0]    rd_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_ACTIVE) begin
            r_active <= pwdata[ACT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ACTIVE) ? APB_DW'(r_active) : '0;

    efws_ctrl #(
        .USED  (USED),
        .CNT_W (CNT_W),
        .AW    (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_active   (r_active),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr)
    );

    efws_dp #(
        .USED      (USED),
        .AW        (AW),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_rd_addr      (rd_addr),
        .i_job_duration (i_job_duration),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_worker_index (o_worker_index),
        .o_start_time   (o_start_time)
    );

endmodule
`default_nettype wire
